// File: rtl/core/kpad_pkg.sv
package kpad_pkg;

    localparam int TABLE_ENTRIES   = 14;
    localparam int DEFINED_ENTRIES = 14;
    localparam int SCAN_LIMIT      = (TABLE_ENTRIES > DEFINED_ENTRIES) ?
                                     DEFINED_ENTRIES : TABLE_ENTRIES;

    localparam int WORD_W    = 32;
    localparam int TICK_W    = 32;
    localparam int DELAY_W   = 16;
    localparam int KEY_IDX_W = 4;
    localparam int CFG_IDX_W = 1;
    localparam int DOWN_W    = 1 << KEY_IDX_W;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY = 1'd1;

    localparam logic [DELAY_W-1:0] FIRST_DELAY_RST  = 16'd500;
    localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST = 16'd175;

    localparam logic [KEY_IDX_W-1:0] KEY_NONE = '0;

    // Entry i reads group one when bit i is set, group two otherwise
    localparam logic [DEFINED_ENTRIES-1:0] KEY_IN_GROUP1 = 14'b00_0000_0100_0000;

    localparam logic [WORD_W-1:0] KEY_MASK [DEFINED_ENTRIES] = '{
        32'h0000_2000, 32'h0000_0100, 32'h0000_0200,
        32'h0000_0800, 32'h0000_0400, 32'h0000_1000,
        32'h1000_0000, 32'h0000_8000, 32'h0000_4000,
        32'h0000_0010, 32'h0000_0020, 32'h0000_000C,
        32'h0000_0008, 32'h0000_0004
    };

    typedef struct packed {
        logic [WORD_W-1:0] keys_group1;
        logic [WORD_W-1:0] keys_group2;
        logic [TICK_W-1:0] tick_now;
        logic              clear_repeat;
    } t_in;

    typedef struct packed {
        logic [KEY_IDX_W-1:0] pressed_index;
        logic [KEY_IDX_W-1:0] clicked_index;
        logic [KEY_IDX_W-1:0] repeat_index;
    } t_out;

    // down[k] is set when table entry k (1-based) is down now; down[0] stays 0
    typedef struct packed {
        logic [KEY_IDX_W-1:0] pressed;
        logic [KEY_IDX_W-1:0] clicked;
        logic [DOWN_W-1:0]    down;
    } t_scan;

endpackage

// File: rtl/core/kpad_scan.sv
module kpad_scan
    import kpad_pkg::*;
(
    input  logic [WORD_W-1:0] i_now_group1,
    input  logic [WORD_W-1:0] i_now_group2,
    input  logic [WORD_W-1:0] i_prev_group1,
    input  logic [WORD_W-1:0] i_prev_group2,
    output t_scan             o_scan
);

    logic [DEFINED_ENTRIES-1:0] now_down;
    logic [DEFINED_ENTRIES-1:0] prev_down;

    always_comb begin
        for (int i = 0; i < DEFINED_ENTRIES; i++) begin
            if (KEY_IN_GROUP1[i]) begin
                now_down[i]  = (i_now_group1  & KEY_MASK[i]) == '0;
                prev_down[i] = (i_prev_group1 & KEY_MASK[i]) == '0;
            end else begin
                now_down[i]  = (i_now_group2  & KEY_MASK[i]) == '0;
                prev_down[i] = (i_prev_group2 & KEY_MASK[i]) == '0;
            end
        end
    end

    // Walk from the lowest priority up so the first entry wins
    always_comb begin
        o_scan.pressed = KEY_NONE;
        o_scan.clicked = KEY_NONE;
        o_scan.down    = '0;
        for (int i = SCAN_LIMIT - 1; i >= 0; i--) begin
            o_scan.down[i+1] = now_down[i];
            if (now_down[i]) begin
                o_scan.pressed = KEY_IDX_W'(i + 1);
            end
            if (now_down[i] && !prev_down[i]) begin
                o_scan.clicked = KEY_IDX_W'(i + 1);
            end
        end
    end

endmodule

// File: rtl/core/keypad_click_and_autorepeat_core.sv
// Channel   Direction  Handshake                  Beat
// -------   ---------  -------------------------  ------------------------------
// in        input      i_in_valid / o_in_ready    t_in: two key words, tick, clear
// out       output     o_out_valid / i_out_ready  t_out: pressed, clicked, repeat
// cfg       input      i_cfg_we (no wait)         index 0 first_delay, 1 repeat
//
// Two stages: input register, then scan and repeat timer into the result register.
// One poll per cycle unless results stall; a poll goes via input to result register.
// Synchronous active-low reset clears state and restores delays to 500 and 175.
// A stalled result holds in its register; the input register keeps one more poll.
module keypad_click_and_autorepeat_core
    import kpad_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DELAY_W-1:0]   i_cfg_data
);

    logic                 r_in_valid;
    t_in                  r_in;
    logic                 r_out_valid;
    t_out                 r_out;

    logic [DELAY_W-1:0]   r_first_delay;
    logic [DELAY_W-1:0]   r_repeat_delay;
    logic [WORD_W-1:0]    r_prev_group1;
    logic [WORD_W-1:0]    r_prev_group2;
    logic [KEY_IDX_W-1:0] r_held_key;
    logic [TICK_W-1:0]    r_last_emit;
    logic                 r_repeating;

    logic [KEY_IDX_W-1:0] n_held_key;
    logic [TICK_W-1:0]    n_last_emit;
    logic                 n_repeating;
    t_out                 n_out;

    logic                 advance;
    t_scan                scan;
    logic [KEY_IDX_W-1:0] held_eff;
    logic [TICK_W-1:0]    elapsed;
    logic [DELAY_W-1:0]   delay;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    kpad_scan u_scan (
        .i_now_group1  (r_in.keys_group1),
        .i_now_group2  (r_in.keys_group2),
        .i_prev_group1 (r_prev_group1),
        .i_prev_group2 (r_prev_group2),
        .o_scan        (scan)
    );

    assign held_eff = r_in.clear_repeat ? KEY_NONE : r_held_key;
    assign elapsed  = r_in.tick_now - r_last_emit;
    assign delay    = r_repeating ? r_repeat_delay : r_first_delay;

    always_comb begin
        n_held_key          = held_eff;
        n_last_emit         = r_last_emit;
        n_repeating         = r_repeating;
        n_out.pressed_index = scan.pressed;
        n_out.clicked_index = scan.clicked;
        n_out.repeat_index  = KEY_NONE;
        if (scan.clicked != KEY_NONE) begin
            n_held_key         = scan.clicked;
            n_repeating        = 1'b0;
            n_last_emit        = r_in.tick_now;
            n_out.repeat_index = scan.clicked;
        end else if (held_eff != KEY_NONE && scan.down[held_eff]) begin
            if (elapsed > TICK_W'(delay)) begin
                n_repeating        = 1'b1;
                n_last_emit        = r_in.tick_now;
                n_out.repeat_index = held_eff;
            end
        end else begin
            // drop a released key; repeating waits for the next click
            n_held_key = KEY_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_first_delay  <= FIRST_DELAY_RST;
            r_repeat_delay <= REPEAT_DELAY_RST;
            r_prev_group1  <= '0;
            r_prev_group2  <= '0;
            r_held_key     <= KEY_NONE;
            r_last_emit    <= '0;
            r_repeating    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FIRST_DELAY:  r_first_delay  <= i_cfg_data;
                    CFG_REPEAT_DELAY: r_repeat_delay <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid   <= 1'b1;
                r_prev_group1 <= r_in.keys_group1;
                r_prev_group2 <= r_in.keys_group2;
                r_held_key    <= n_held_key;
                r_last_emit   <= n_last_emit;
                r_repeating   <= n_repeating;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

// File: rtl/core/kpad_checker.sv
module kpad_checker
    import kpad_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  t_out                 o_out
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a click always fires the repeat output with the same key
    a_click_repeats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.clicked_index != KEY_NONE |->
            o_out.repeat_index == o_out.clicked_index)
        else $error("click without matching repeat");

    a_click_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.clicked_index != KEY_NONE |->
            o_out.pressed_index != KEY_NONE &&
            o_out.pressed_index <= o_out.clicked_index)
        else $error("clicked key not covered by pressed key");

endmodule

bind keypad_click_and_autorepeat_core kpad_checker u_kpad_checker (.*);
